>>> rtl/dac_bivariate_poly_tcomp_assert.svh
// assertion macros used by the temperature compensation top module
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef DAC_BIVARIATE_POLY_TCOMP_ASSERT_SVH
`define DAC_BIVARIATE_POLY_TCOMP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define DBPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define DBPT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

>>> rtl/dbpt_pkg.sv
// types and constants for the bivariate polynomial temperature compensation
// used by dbpt_mac, dbpt_seq, the top module and the testbench; no dependencies
`default_nettype none

package dbpt_pkg;

    localparam int VAL_W       = 48;
    localparam int TEMP_DEGREE = 3;
    localparam int INNER_SHIFT = 15;
    localparam int OUTER_SHIFT = 16;

    localparam logic signed [63:0] VAL_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] VAL_MIN = -64'sd140737488355328;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_EN   = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LOADC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_DONE
    } seq_state_t;

    // datapath strobes from the sequencer
    typedef struct packed {
        logic clr_acc;
        logic load_c;
        logic mul_lo;
        logic mul_hi;
        logic add_step;
        logic outer;
    } mac_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

`default_nettype wire

>>> rtl/dbpt_coef_mem.sv
// coefficient store: one write port, one registered read port
// depends on nothing but its parameters
`default_nettype none

module dbpt_coef_mem #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 48
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/dbpt_mac.sv
// shared multiply-accumulate unit: 25x17 signed multiplier used twice per product,
// round-shift, add and saturate; depends on dbpt_pkg
`default_nettype none

module dbpt_mac
    import dbpt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire mac_ctrl_t               ctl,
    input  wire logic signed [15:0]      temperature,
    input  wire logic        [15:0]      raw_code,
    input  wire logic        [VAL_W-1:0] coef_rdata,
    output logic signed      [VAL_W-1:0] acc
);

    logic signed [VAL_W-1:0] c_reg;
    logic signed [VAL_W-1:0] acc_reg;
    logic signed [63:0]      psum_reg;

    logic signed [VAL_W-1:0] op_a;
    logic signed [24:0]      a_lo;
    logic signed [24:0]      a_hi;
    logic signed [24:0]      mul_a;
    logic signed [16:0]      m_op;
    logic signed [41:0]      prod;
    logic signed [63:0]      prod_ext;
    logic signed [63:0]      rnd_const;
    logic signed [63:0]      shifted;
    logic signed [63:0]      addend;
    logic signed [63:0]      sum;
    logic signed [VAL_W-1:0] sat_val;

    always_comb begin
        op_a  = ctl.outer ? acc_reg : c_reg;
        // low half enters unsigned, high half carries the sign
        a_lo  = signed'({1'b0, op_a[23:0]});
        a_hi  = signed'({op_a[VAL_W-1], op_a[VAL_W-1:24]});
        mul_a = ctl.mul_hi ? a_hi : a_lo;
        m_op  = ctl.outer ? signed'({1'b0, raw_code})
                          : signed'({temperature[15], temperature});
        prod     = mul_a * m_op;
        prod_ext = {{22{prod[41]}}, prod};
        rnd_const = ctl.outer ? (64'sd1 <<< (OUTER_SHIFT - 1))
                              : (64'sd1 <<< (INNER_SHIFT - 1));
        shifted = ctl.outer ? (psum_reg >>> OUTER_SHIFT) : (psum_reg >>> INNER_SHIFT);
        addend  = ctl.outer ? {{16{c_reg[VAL_W-1]}}, c_reg}
                            : {{16{coef_rdata[VAL_W-1]}}, coef_rdata};
        sum = shifted + addend;
        if (sum > VAL_MAX) begin
            sat_val = VAL_MAX[VAL_W-1:0];
        end else if (sum < VAL_MIN) begin
            sat_val = VAL_MIN[VAL_W-1:0];
        end else begin
            sat_val = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_lo) begin
            psum_reg <= prod_ext + rnd_const;
        end
        if (ctl.mul_hi) begin
            psum_reg <= psum_reg + (prod_ext <<< 24);
        end
        if (ctl.clr_acc) begin
            acc_reg <= '0;
        end
        if (ctl.load_c) begin
            c_reg <= coef_rdata;
        end
        if (ctl.add_step) begin
            if (ctl.outer) begin
                acc_reg <= sat_val;
            end else begin
                c_reg <= sat_val;
            end
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> rtl/dbpt_seq.sv
// sequencer: walks the coefficient groups, drives the mac strobes and store address
// depends on dbpt_pkg
`default_nettype none

module dbpt_seq
    import dbpt_pkg::*;
#(
    parameter int COEF_COUNT = 16,
    parameter int ADDR_W     = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] base_addr,
    input  wire logic              out_free,
    output mac_ctrl_t              mac_ctl,
    output seq_stat_t              stat,
    output logic      [ADDR_W-1:0] rd_addr
);

    localparam int GROUPS = COEF_COUNT / (TEMP_DEGREE + 1);
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [1:0]        deg_reg, deg_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic              outer_reg, outer_next;

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        deg_next   = deg_reg;
        grp_next   = grp_reg;
        outer_next = outer_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ptr_next   = base_addr;
                    grp_next   = '0;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                ptr_next   = ptr_reg + 1'b1;
                state_next = ST_LOADC;
            end
            ST_LOADC: begin
                deg_next   = '0;
                outer_next = 1'b0;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (!outer_reg) begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_MUL_LO;
                    if (deg_reg == 2'(TEMP_DEGREE - 1)) begin
                        outer_next = 1'b1;
                    end else begin
                        deg_next = deg_reg + 1'b1;
                    end
                end else if (grp_reg == GRP_W'(GROUPS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = ST_FIRST;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mac_ctl       = '0;
        mac_ctl.outer = outer_reg;
        stat          = '0;
        case (state_reg)
            ST_IDLE: begin
                stat.idle       = 1'b1;
                mac_ctl.clr_acc = start;
            end
            ST_LOADC: begin
                mac_ctl.load_c = 1'b1;
            end
            ST_MUL_LO: begin
                mac_ctl.mul_lo = 1'b1;
            end
            ST_MUL_HI: begin
                mac_ctl.mul_hi = 1'b1;
            end
            ST_ADD: begin
                mac_ctl.add_step = 1'b1;
            end
            ST_DONE: begin
                stat.done = out_free;
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            outer_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            outer_reg <= outer_next;
        end
        ptr_reg <= ptr_next;
        deg_reg <= deg_next;
        grp_reg <= grp_next;
    end

    assign rd_addr = ptr_reg;

endmodule

`default_nettype wire

>>> rtl/dac_bivariate_poly_tcomp.sv
// Temperature compensation of a DAC code by a bivariate cubic polynomial, Q24.24 result.
// A load transaction writes one coefficient; a compute transaction with compensation
// disabled passes the code through. An enabled compute walks the groups of four
// coefficients and then hands the result to the output register: each of the 16
// multiply-adds at the default size takes three passes through the one shared 25x17
// multiplier and saturating adder (low half product, high half product, round-shift-add),
// and each group first fetches its leading coefficient through the store's registered read.
// The input side is held off while a compute runs or an undelivered result occupies
// the output register. Configuration writes are taken every cycle.
// depends on dbpt_pkg, dbpt_coef_mem, dbpt_mac, dbpt_seq and the assertion macros
`default_nettype none
`include "dac_bivariate_poly_tcomp_assert.svh"

module dac_bivariate_poly_tcomp
    import dbpt_pkg::*;
#(
    parameter int COEF_COUNT = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [1:0]              cfg_data,
    // input transactions
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_operation,
    input  wire logic                    s_coef_set,
    input  wire logic [3:0]              s_coef_index,
    input  wire logic signed [VAL_W-1:0] s_coef_value,
    input  wire logic signed [15:0]      s_temperature,
    input  wire logic [15:0]             s_raw_code,
    // result transactions
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VAL_W-1:0]      m_compensated_code
);

    localparam int ADDR_W = $clog2(2 * COEF_COUNT);

    logic                    loop_mode_reg;
    logic [1:0]              comp_en_reg;
    logic signed [15:0]      temp_reg;
    logic [15:0]             code_reg;
    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] m_code_reg;

    logic                    s_accept;
    logic                    out_free;
    logic                    mode_en;
    logic                    start;
    logic                    pass_load;
    logic                    coef_we;
    logic [ADDR_W-1:0]       set_base;
    logic [ADDR_W-1:0]       base_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [VAL_W-1:0]        coef_rdata;
    logic signed [VAL_W-1:0] acc;
    mac_ctrl_t               mac_ctl;
    seq_stat_t               stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_mode_reg <= 1'b0;
            comp_en_reg   <= 2'b00;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOOP_MODE: loop_mode_reg <= cfg_data[0];
                REG_COMP_EN:   comp_en_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = stat.idle && out_free;
    assign s_accept  = s_valid && s_ready;
    assign mode_en   = loop_mode_reg ? comp_en_reg[1] : comp_en_reg[0];
    assign start     = s_accept && (s_operation == OP_COMPUTE) && mode_en;
    assign pass_load = s_accept && (s_operation == OP_COMPUTE) && !mode_en;
    assign coef_we   = s_accept && (s_operation == OP_LOAD)
                       && (32'(s_coef_index) < COEF_COUNT);
    assign set_base  = ADDR_W'(COEF_COUNT);
    assign base_addr = loop_mode_reg ? set_base : '0;
    assign wr_addr   = (s_coef_set ? set_base : '0) + ADDR_W'(s_coef_index);

    always_ff @(posedge aclk) begin
        if (start) begin
            temp_reg <= s_temperature;
            code_reg <= s_raw_code;
        end
    end

    dbpt_coef_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (coef_we),
        .wr_addr (wr_addr),
        .wr_data (s_coef_value),
        .rd_addr (rd_addr),
        .rd_data (coef_rdata)
    );

    dbpt_seq #(
        .COEF_COUNT (COEF_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .base_addr (base_addr),
        .out_free  (out_free),
        .mac_ctl   (mac_ctl),
        .stat      (stat),
        .rd_addr   (rd_addr)
    );

    dbpt_mac u_mac (
        .aclk        (aclk),
        .ctl         (mac_ctl),
        .temperature (temp_reg),
        .raw_code    (code_reg),
        .coef_rdata  (coef_rdata),
        .acc         (acc)
    );

    // output register: pass-through code or finished polynomial
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pass_load || stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (pass_load) begin
            m_code_reg <= {24'd0, s_raw_code, 8'd0};
        end else if (stat.done) begin
            m_code_reg <= acc;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_compensated_code = m_code_reg;

    `DBPT_ASSERT(a_no_result_overwrite, (pass_load || stat.done) |-> out_free, "lost result")
    `DBPT_ASSERT_NEVER(a_store_write_busy, coef_we && !stat.idle, "store written while busy")
    `DBPT_ASSERT(a_start_leaves_idle, start |=> !stat.idle, "sequencer did not start")
    `DBPT_ASSERT(a_done_gives_result, stat.done |=> m_valid_reg, "no result after evaluation")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// testbench for dac_bivariate_poly_tcomp: coefficient loads and compensation transactions
// checked against a bit-accurate predictor of the q24.24 polynomial, with random idling
// depends on dbpt_pkg and the dac_bivariate_poly_tcomp rtl
`timescale 1ns / 100ps

module tb_top;
    import dbpt_pkg::*;

    localparam int COEF_COUNT    = 16;
    localparam int GROUPS        = COEF_COUNT / (TEMP_DEGREE + 1);
    localparam int IDLE_PCT      = 19;
    localparam int SETTLE_CYCLES = 70;
    localparam int PHASE_ITEMS   = 215;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;

    typedef struct {
        logic                    op;
        logic                    set;
        logic [3:0]              idx;
        logic signed [VAL_W-1:0] value;
        logic signed [15:0]      temp;
        logic [15:0]             code;
    } tcomp_item_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [1:0]              cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_operation = OP_LOAD;
    logic                    s_coef_set = 1'b0;
    logic [3:0]              s_coef_index = '0;
    logic signed [VAL_W-1:0] s_coef_value = '0;
    logic signed [15:0]      s_temperature = '0;
    logic [15:0]             s_raw_code = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VAL_W-1:0] m_compensated_code;

    // predictor state
    logic signed [VAL_W-1:0] coef_bank [2*COEF_COUNT];
    logic                    loop_mode;
    logic [1:0]              comp_en;
    logic signed [VAL_W-1:0] expected_codes [$];

    int  mismatches = 0;
    bit  steady_flow = 1'b0;

    dac_bivariate_poly_tcomp #(
        .COEF_COUNT(COEF_COUNT)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_coef_set        (s_coef_set),
        .s_coef_index      (s_coef_index),
        .s_coef_value      (s_coef_value),
        .s_temperature     (s_temperature),
        .s_raw_code        (s_raw_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_compensated_code(m_compensated_code)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [63:0] clamp_q24(input logic signed [63:0] v);
        if (v > VAL_MAX)
            return VAL_MAX;
        if (v < VAL_MIN)
            return VAL_MIN;
        return v;
    endfunction

    // add half an lsb then floor, so ties go towards plus infinity
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] p, input int n);
        return (p + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [VAL_W-1:0] poly_code(input logic sel,
                                                          input logic signed [15:0] temp,
                                                          input logic [15:0] code);
        logic signed [63:0] acc;
        logic signed [63:0] c;
        logic signed [63:0] t;
        logic signed [63:0] x;
        int pos;
        acc = '0;
        t = 64'(temp);
        x = {48'd0, code};
        pos = sel * COEF_COUNT;
        for (int g = 0; g < GROUPS; g++) begin
            c = coef_bank[pos++];
            for (int d = 0; d < TEMP_DEGREE; d++)
                c = clamp_q24(round_shift(c * t, INNER_SHIFT) + coef_bank[pos++]);
            acc = clamp_q24(round_shift(acc * x, OUTER_SHIFT) + c);
        end
        return acc[VAL_W-1:0];
    endfunction

    function automatic void apply_item(input tcomp_item_t it);
        logic enabled;
        if (it.op == OP_LOAD) begin
            coef_bank[it.set * COEF_COUNT + it.idx] = it.value;
        end else begin
            enabled = loop_mode ? comp_en[1] : comp_en[0];
            if (enabled)
                expected_codes.push_back(poly_code(loop_mode, it.temp, it.code));
            else
                expected_codes.push_back({24'd0, it.code, 8'd0});
        end
    endfunction

    // result side: check on handshake, then pick the next ready
    always @(posedge aclk) begin
        logic signed [VAL_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_compensated_code));
                end else begin
                    want = expected_codes.pop_front();
                    if (m_compensated_code !== want)
                        report_mismatch($sformatf("compensated_code %h, predicted %h",
                                                  m_compensated_code, want));
                end
            end
            m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // valid is left high on return so back-to-back transactions need no second assignment
    task automatic send_item(input tcomp_item_t it);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= it.op;
        s_coef_set    <= it.set;
        s_coef_index  <= it.idx;
        s_coef_value  <= it.value;
        s_temperature <= it.temp;
        s_raw_code    <= it.code;
        do
            @(posedge aclk);
        while (!s_ready);
        apply_item(it);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge aclk);
    endtask

    // loads leave no result behind, so allow a full compute to finish as well
    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        if (idx == REG_LOOP_MODE)
            loop_mode = data[0];
        else if (idx == REG_COMP_EN)
            comp_en = data;
    endtask

    // upper data bit of the loop mode write must be masked off
    task automatic set_mode(input logic lm, input logic [1:0] en);
        settle_block();
        write_reg(REG_LOOP_MODE, {1'($urandom_range(1)), lm});
        write_reg(REG_COMP_EN, en);
        write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(1)), 2'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] random_coef();
        logic signed [63:0] raw;
        int w;
        case ($urandom_range(31))
            0: return VAL_MAX[VAL_W-1:0];
            1: return VAL_MIN[VAL_W-1:0];
            default: begin
                w = $urandom_range(VAL_W, 1);
                raw = {$urandom, $urandom};
                raw = raw <<< (64 - w);
                raw = raw >>> (64 - w);
                return raw[VAL_W-1:0];
            end
        endcase
    endfunction

    function automatic tcomp_item_t random_item(input int load_pct);
        tcomp_item_t it;
        it.op    = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_COMPUTE;
        it.set   = 1'($urandom_range(1));
        it.idx   = 4'($urandom_range(COEF_COUNT - 1));
        it.value = random_coef();
        it.temp  = 16'($urandom);
        it.code  = 16'($urandom);
        case ($urandom_range(15))
            0: it.temp = 16'sh8000;
            1: it.temp = 16'sh7fff;
            2: it.code = 16'h0000;
            3: it.code = 16'hffff;
            default: ;
        endcase
        return it;
    endfunction

    function automatic tcomp_item_t compute_item(input logic signed [15:0] temp,
                                                 input logic [15:0] code);
        tcomp_item_t it;
        it = random_item(0);
        it.temp = temp;
        it.code = code;
        return it;
    endfunction

    // compensation off: code comes back shifted into q24.24, store untouched
    task automatic test_passthrough();
        set_mode(1'b0, 2'b00);
        send_item(compute_item(16'sh0000, 16'h0000));
        send_item(compute_item(16'sh7fff, 16'hffff));
        send_item(compute_item(16'sh8000, 16'h8000));
        send_item(compute_item(-16'sd1, 16'h0001));
        set_mode(1'b1, 2'b01);
        send_item(compute_item(16'sh4000, 16'h00ff));
        send_item(compute_item(-16'sh4000, 16'hff00));
        set_mode(1'b0, 2'b10);
        send_item(compute_item(16'sh1234, 16'h5a5a));
        send_item(compute_item(16'sh7fff, 16'ha5a5));
    endtask

    // 0-5 mA set gets small values to expose rounding ties, 4-20 mA set the extremes
    task automatic test_coef_load();
        tcomp_item_t it;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < COEF_COUNT; i++) begin
                it = random_item(100);
                it.set = 1'(s);
                it.idx = 4'(i);
                if (s == 0)
                    it.value = VAL_W'((i % 2) ? -(i + 1) : (i + 1));
                else
                    it.value = (i % 2) ? VAL_MIN[VAL_W-1:0] : VAL_MAX[VAL_W-1:0];
                send_item(it);
            end
        end
    endtask

    task automatic test_corner_codes();
        for (int s = 0; s < 2; s++) begin
            set_mode(1'(s), s ? 2'b10 : 2'b01);
            send_item(compute_item(16'sh8000, 16'h0000));
            send_item(compute_item(16'sh7fff, 16'hffff));
            send_item(compute_item(16'sh8000, 16'hffff));
            send_item(compute_item(16'sh4000, 16'h8000));
            send_item(compute_item(-16'sh4000, 16'h8000));
            send_item(compute_item(-16'sd1, 16'h0001));
        end
    endtask

    // phases walk the mode settings, extremes first; one runs without idling
    task automatic test_random_traffic();
        logic [2:0] plan [8] = '{3'b0_00, 3'b1_11, 3'b0_01, 3'b1_10,
                                 3'b0_11, 3'b1_01, 3'b0_10, 3'b1_00};
        for (int p = 0; p < 8; p++) begin
            set_mode(plan[p][2], plan[p][1:0]);
            steady_flow = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_results_drained();
                send_item(random_item(25));
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        loop_mode = 1'b0;
        comp_en   = 2'b00;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_coef_load();
        test_corner_codes();
        test_random_traffic();

        settle_block();
        if (expected_codes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_codes.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
